FILE: src/bsfd_pkg.sv
// ----------------------------------------------------------------------------
// bsfd_pkg
// Shared types and constants of the byte-stuffed frame deframer.
// ----------------------------------------------------------------------------
package bsfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 11;
    localparam int PLEN_W    = 4;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] XOR_MASK   = 8'h20;
    localparam logic [BYTE_W-1:0] COUNT_MAX  = 8'hFF;
    localparam logic [BYTE_W-1:0] MIN_FRAME  = 8'd3;
    localparam logic [BYTE_W-1:0] START_RST  = 8'd126;
    localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'd125;

    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0]   frame_address;
        logic [PLEN_W-1:0]   payload_length;
        logic [BYTE_W-1:0]   frame_length;
        logic [STATUS_W-1:0] frame_status;
    } t_result;

endpackage

FILE: src/bsfd_unstuff.sv
// ----------------------------------------------------------------------------
// bsfd_unstuff
// Frame state: escape flag, byte count and header bytes, with the
// summary of a frame when a start byte closes it.
// ----------------------------------------------------------------------------
module bsfd_unstuff
    import bsfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_start_byte,
    input  logic [BYTE_W-1:0] i_escape_byte,
    output logic              o_close,
    output t_result           o_result
);

    logic              r_armed, n_armed;
    logic [BYTE_W-1:0] r_count, n_count;
    logic [BYTE_W-1:0] r_hdr0, n_hdr0;
    logic [BYTE_W-1:0] r_hdr1, n_hdr1;

    logic              is_start;
    logic              is_escape;
    logic [BYTE_W-1:0] plain;
    logic [BYTE_W-1:0] expect_len;

    assign is_start  = (i_byte == i_start_byte);
    assign is_escape = (i_byte == i_escape_byte);
    assign plain     = r_armed ? (i_byte ^ XOR_MASK) : i_byte;
    assign o_close   = is_start && (r_count != '0);

    always_comb begin
        n_armed = r_armed;
        n_count = r_count;
        n_hdr0  = r_hdr0;
        n_hdr1  = r_hdr1;
        if (is_start) begin
            n_count = '0;
        end else if (is_escape) begin
            n_armed = 1'b1;
        end else begin
            n_armed = 1'b0;
            if (r_count == 8'd0) begin
                n_hdr0 = plain;
            end
            if (r_count == 8'd1) begin
                n_hdr1 = plain;
            end
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 8'd1;
            end
        end
    end

    always_comb begin
        expect_len = {4'b0, r_hdr1[PLEN_W-1:0]} + MIN_FRAME;
        o_result.frame_length = r_count;
        if (r_count < MIN_FRAME) begin
            o_result.frame_address  = '0;
            o_result.payload_length = '0;
            o_result.frame_status   = ST_SHORT;
        end else begin
            o_result.frame_address  = {r_hdr0, r_hdr1[7:5]};
            o_result.payload_length = r_hdr1[PLEN_W-1:0];
            o_result.frame_status   = (r_count != expect_len) ? ST_MISMATCH : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_count <= '0;
        end else if (i_en) begin
            r_armed <= n_armed;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hdr0 <= n_hdr0;
            r_hdr1 <= n_hdr1;
        end
    end

endmodule

FILE: src/byte_stuffed_frame_deframer.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_deframer
// Removes byte stuffing from a received stream and reports each closed frame.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one received byte (i_rx_byte) per
// item. Output channel: o_valid / i_stall carry one frame summary per item:
// address, payload length, frame length and status. A summary is issued when
// a start byte closes a frame that holds at least one byte.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 sets the start byte, index 1 the escape byte, other indices are
// ignored. o_cfg_ready is always high; write only while the block is idle.
// A byte is registered in the input register at acceptance and is processed
// from there; a closing byte's summary is registered in the result register.
// Throughput: one byte per cycle while o_stall is low, set by the single
// input register and the single result register, which can both take a new
// value in every cycle. Reset clears the escape flag, the byte count, both
// valid flags and restores the start byte 126 and escape byte 125.
// While the receiver stalls, the result register holds its summary; bytes
// that close no frame keep flowing, and a byte that would close a frame waits
// in the input register, which then raises o_stall.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_deframer
    import bsfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ADDR_W-1:0]    o_frame_address,
    output logic [PLEN_W-1:0]    o_payload_length,
    output logic [BYTE_W-1:0]    o_frame_length,
    output logic [STATUS_W-1:0]  o_frame_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_escape_byte;

    logic    close;
    t_result result;
    logic    out_free;
    logic    advance;
    logic    in_take;

    bsfd_unstuff u_unstuff (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_byte        (r_in_byte),
        .i_start_byte  (r_start_byte),
        .i_escape_byte (r_escape_byte),
        .o_close       (close),
        .o_result      (result)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && (!close || out_free);
    assign o_stall  = r_in_valid && !advance;
    assign in_take  = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= START_RST;
            r_escape_byte <= ESCAPE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START:  r_start_byte  <= i_cfg_data;
                CFG_ESCAPE: r_escape_byte <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && close) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && close) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_frame_address  = r_out.frame_address;
    assign o_payload_length = r_out.payload_length;
    assign o_frame_length   = r_out.frame_length;
    assign o_frame_status   = r_out.frame_status;

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_status == ST_OK)
            |-> (o_frame_length == {4'b0, o_payload_length} + MIN_FRAME))
        else $error("ok status with inconsistent length");

    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_status == ST_SHORT)
            |-> (o_frame_length < MIN_FRAME && o_frame_length != '0
                 && o_frame_address == '0))
        else $error("short frame summary malformed");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (close && r_out_valid && i_stall))
        else $error("input stalled without a blocked summary");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("stalled summary dropped");

endmodule

FILE: tb/byte_stuffed_frame_deframer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_stuffed_frame_deframer_tb
// Self-checking bench for the byte-stuffed frame deframer. Bytes are fed as
// well-formed frames with random content, mismatched and short frames,
// escape and start noise and one over-long frame, under several start and
// escape settings. A predictor in the bench tracks escape state, byte count
// and header bytes, and every frame summary is compared with its prediction.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_deframer_tb;
    import bsfd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int REPORT_MAX     = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    class deframer_predictor;
        logic [BYTE_W-1:0] start_reg;
        logic [BYTE_W-1:0] escape_reg;
        bit                escape_armed;
        logic [BYTE_W-1:0] byte_count;
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        t_result           pending_summaries[$];
        int unsigned       mismatches;

        function new();
            start_reg     = START_RST;
            escape_reg    = ESCAPE_RST;
            escape_armed  = 1'b0;
            byte_count    = '0;
            header_first  = '0;
            header_second = '0;
            mismatches    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [BYTE_W-1:0] data);
            case (index)
                CFG_START:  start_reg  = data;
                CFG_ESCAPE: escape_reg = data;
                default: ;
            endcase
        endfunction

        function void take_byte(logic [BYTE_W-1:0] rx);
            logic [BYTE_W-1:0] c;
            t_result           s;
            c = rx;
            if (c == start_reg) begin
                if (byte_count != 0) begin
                    s = '0;
                    s.frame_length = byte_count;
                    if (byte_count < MIN_FRAME) begin
                        s.frame_status = ST_SHORT;
                    end else begin
                        s.frame_address  = {header_first, header_second[7:5]};
                        s.payload_length = header_second[3:0];
                        s.frame_status   = (byte_count != {4'd0, header_second[3:0]} + MIN_FRAME)
                                           ? ST_MISMATCH : ST_OK;
                    end
                    pending_summaries.push_back(s);
                end
                byte_count = '0;
                return;
            end
            if (c == escape_reg) begin
                escape_armed = 1'b1;
                return;
            end
            if (escape_armed) begin
                c = c ^ XOR_MASK;
                escape_armed = 1'b0;
            end
            if (byte_count == 0) begin
                header_first = c;
            end else if (byte_count == 1) begin
                header_second = c;
            end
            if (byte_count != COUNT_MAX) begin
                byte_count = byte_count + 1'b1;
            end
        endfunction

        function void match_summary(t_result got);
            t_result want;
            if (pending_summaries.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("%0t: unexpected summary addr %0h plen %0d len %0d status %0d",
                             $time, got.frame_address, got.payload_length,
                             got.frame_length, got.frame_status);
                end
                return;
            end
            want = pending_summaries.pop_front();
            if (got.frame_address !== want.frame_address
                    || got.payload_length !== want.payload_length
                    || got.frame_length !== want.frame_length
                    || got.frame_status !== want.frame_status) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("%0t: summary mismatch expected addr %0h plen %0d len %0d status %0d",
                             $time, want.frame_address, want.payload_length,
                             want.frame_length, want.frame_status);
                    $display("%0t:                  actual   addr %0h plen %0d len %0d status %0d",
                             $time, got.frame_address, got.payload_length,
                             got.frame_length, got.frame_status);
                end
            end
        endfunction

        function int pending();
            return pending_summaries.size();
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic [BYTE_W-1:0]    i_rx_byte   = '0;
    logic                 i_stall     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BYTE_W-1:0]    i_cfg_data  = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic [ADDR_W-1:0]    o_frame_address;
    logic [PLEN_W-1:0]    o_payload_length;
    logic [BYTE_W-1:0]    o_frame_length;
    logic [STATUS_W-1:0]  o_frame_status;
    logic                 o_cfg_ready;

    deframer_predictor predictor = new();

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int unsigned bytes_sent    = 0;
    int          hold_trigger  = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    int          quiet_cycles  = 0;

    byte_stuffed_frame_deframer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_address  (o_frame_address),
        .o_payload_length (o_payload_length),
        .o_frame_length   (o_frame_length),
        .o_frame_status   (o_frame_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // summary side: check accepted items and drive stall
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            predictor.match_summary({o_frame_address, o_payload_length,
                                     o_frame_length, o_frame_status});
        end
        if (hold_seen != hold_trigger) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] rx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid   <= 1'b0;
            i_rx_byte <= BYTE_W'($urandom);
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predictor.take_byte(rx);
        bytes_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] ordinary_byte();
        logic [BYTE_W-1:0] b;
        do b = BYTE_W'($urandom);
        while (b == predictor.start_reg || b == predictor.escape_reg);
        return b;
    endfunction

    // put one unescaped value on the line, stuffing it where needed or at random, or a stand-in where it cannot be
    task automatic send_unescaped(input logic [BYTE_W-1:0] d);
        logic [BYTE_W-1:0] wire_val;
        bit                can_escape;
        wire_val   = d ^ XOR_MASK;
        can_escape = predictor.escape_reg != predictor.start_reg
                     && wire_val != predictor.start_reg && wire_val != predictor.escape_reg;
        if (can_escape && (d == predictor.start_reg || d == predictor.escape_reg
                           || $urandom_range(9) == 0)) begin
            send_byte(predictor.escape_reg);
            send_byte(wire_val);
        end else if (d != predictor.start_reg && d != predictor.escape_reg) begin
            send_byte(d);
        end else begin
            send_byte(ordinary_byte());
        end
    endtask

    task automatic send_frame(input int n_bytes, input logic [PLEN_W-1:0] plen);
        logic [BYTE_W-1:0] d;
        send_byte(predictor.start_reg);
        for (int i = 0; i < n_bytes; i++) begin
            d = BYTE_W'($urandom);
            if (i == 1) begin
                d[3:0] = plen;
            end
            send_unescaped(d);
        end
    endtask

    task automatic send_noise();
        logic [BYTE_W-1:0] b;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(3))
                0:       b = predictor.start_reg;
                1:       b = predictor.escape_reg;
                default: b = BYTE_W'($urandom);
            endcase
            send_byte(b);
        end
    endtask

    task automatic run_random(input int unsigned until_sent);
        int               pick;
        int               n;
        logic [PLEN_W-1:0] plen;
        while (bytes_sent < until_sent) begin
            pick = $urandom_range(99);
            plen = PLEN_W'($urandom);
            if (pick < 70) begin
                send_frame(plen + 3, plen);
            end else if (pick < 80) begin
                n = $urandom_range(3, 20);
                if (n == plen + 3) begin
                    n++;
                end
                send_frame(n, plen);
            end else if (pick < 90) begin
                send_frame($urandom_range(0, 2), plen);
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (predictor.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [BYTE_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        predictor.write_reg(index, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_random_pair();
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] e;
        s = BYTE_W'($urandom);
        do e = BYTE_W'($urandom);
        while (e == s);
        write_reg(CFG_START, s);
        write_reg(CFG_ESCAPE, e);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 7;
        recv_idle_pct = 50;
        // bytes ahead of any start form a short frame
        send_byte(8'h12);
        send_byte(8'h34);
        send_byte(START_RST);
        send_byte(START_RST);
        send_byte(8'hFF);
        send_byte(8'hE0);
        send_byte(8'h00);
        send_byte(START_RST);
        // escaped start value after the header, length mismatch
        send_byte(8'h00);
        send_byte(8'h0F);
        send_byte(ESCAPE_RST);
        send_byte(START_RST ^ XOR_MASK);
        // start while armed, then repeated escape
        send_byte(ESCAPE_RST);
        send_byte(START_RST);
        send_byte(8'h0A);
        send_byte(ESCAPE_RST);
        send_byte(ESCAPE_RST);
        send_byte(ESCAPE_RST ^ XOR_MASK);
        send_byte(8'h00);
        send_byte(START_RST);
        run_random(320);

        wait_idle();
        write_reg(CFG_START, 8'h00);
        write_reg(CFG_ESCAPE, 8'hFF);
        run_random(570);

        wait_idle();
        send_idle_pct = 50;
        recv_idle_pct = 7;
        write_reg(CFG_START, 8'hFF);
        write_reg(CFG_ESCAPE, 8'h00);
        run_random(820);

        // equal start and escape values, spare indices ignored
        wait_idle();
        write_reg(CFG_START, 8'h55);
        write_reg(CFG_ESCAPE, 8'h55);
        write_reg(CFG_SPARE_LO, 8'hAA);
        write_reg(CFG_SPARE_HI, 8'h00);
        run_random(1040);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_random_pair();
        send_frame(258, PLEN_W'($urandom));
        run_random(1580);

        wait_idle();
        write_random_pair();
        hold_trigger++;
        repeat (12) send_frame($urandom_range(1, 4), PLEN_W'($urandom));
        run_random(1850);
        send_byte(predictor.start_reg);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (predictor.mismatches == 0 && predictor.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
